### hdl/lmq_pkg.sv
// Shared constants and types of the linked multi-queue manager.
package lmq_pkg;

   localparam int DEF_THREAD_COUNT = 64;
   localparam int DEF_LINK_W       = $clog2(DEF_THREAD_COUNT + 1);

   // Request codes on the req_type field
   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_REMOVE  = 2'd2;

   // Decoded operation handed to the sequencer
   typedef enum logic [1:0] {
      OP_NOP = 2'd0,
      OP_ENQ = 2'd1,
      OP_DEQ = 2'd2,
      OP_REM = 2'd3
   } lmq_op_type;

endpackage

### hdl/lmq_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module lmq_ram #(
   parameter int WIDTH = 2 * lmq_pkg::DEF_LINK_W,
   parameter int DEPTH = lmq_pkg::DEF_THREAD_COUNT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lmq_seq.sv
// Sequencer that walks the queue table and link table for each operation.
module lmq_seq #(
   parameter int THREAD_COUNT = lmq_pkg::DEF_THREAD_COUNT,
   localparam int TW = $clog2(THREAD_COUNT),
   localparam int LW = $clog2(THREAD_COUNT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  lmq_pkg::lmq_op_type    op,
   input  logic [LW-1:0]          queue_id,
   input  logic [TW-1:0]          thread_id,
   input  logic                   slot_free,
   output logic                   ready,
   output logic                   done,
   output logic [TW-1:0]          popped,
   output logic                   empty
);

   import lmq_pkg::*;

   localparam logic [LW-1:0] NONE = LW'(THREAD_COUNT);

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_LOOK     = 8'b0000_0100,
      ST_HEADLINK = 8'b0000_1000,
      ST_RMW_A    = 8'b0001_0000,
      ST_RMW_B    = 8'b0010_0000,
      ST_FINAL    = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } seq_state_type;

   function automatic logic is_thread(input logic [LW-1:0] v);
      return v < NONE;
   endfunction

   // entry layout {next, prev}; patch one half
   function automatic logic [2*LW-1:0] set_link(input logic [2*LW-1:0] e,
                                                input logic            sel_next,
                                                input logic [LW-1:0]   v);
      return sel_next ? {v, e[LW-1:0]} : {e[2*LW-1:LW], v};
   endfunction

   seq_state_type   state_ff, state_in;
   lmq_op_type      op_ff, op_in;
   logic [LW-1:0]   q_ff, q_in;
   logic [TW-1:0]   t_ff, t_in;
   logic [LW-1:0]   clr_ff, clr_in;
   logic [TW-1:0]   a_addr_ff, a_addr_in;
   logic            a_nxt_ff, a_nxt_in;
   logic [LW-1:0]   a_val_ff, a_val_in;
   logic            b_en_ff, b_en_in;
   logic [TW-1:0]   b_addr_ff, b_addr_in;
   logic            b_nxt_ff, b_nxt_in;
   logic [LW-1:0]   b_val_ff, b_val_in;
   logic [TW-1:0]   f_addr_ff, f_addr_in;
   logic [2*LW-1:0] f_val_ff, f_val_in;
   logic            fwd_ff, fwd_in;
   logic [2*LW-1:0] fwd_data_ff, fwd_data_in;
   logic [TW-1:0]   popped_ff, popped_in;
   logic            empty_ff, empty_in;

   // queue table port signals, entry {head, tail}
   logic            q_we, q_re;
   logic [LW-1:0]   q_wa, q_ra;
   logic [2*LW-1:0] q_wd, q_rd;
   // link table port signals, entry {next, prev}
   logic            l_we, l_re;
   logic [TW-1:0]   l_wa, l_ra;
   logic [2*LW-1:0] l_wd, l_rd;

   logic [LW-1:0]   q_head, q_tail, l_next, l_prev, t_ext;

   assign q_head = q_rd[2*LW-1:LW];
   assign q_tail = q_rd[LW-1:0];
   assign l_next = l_rd[2*LW-1:LW];
   assign l_prev = l_rd[LW-1:0];
   assign t_ext  = LW'(t_ff);

   lmq_ram #(
      .WIDTH (2 * LW),
      .DEPTH (THREAD_COUNT + 1)
   ) u_lmq_qtab (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wa),
      .wr_data (q_wd),
      .rd_en   (q_re),
      .rd_addr (q_ra),
      .rd_data (q_rd)
   );

   lmq_ram #(
      .WIDTH (2 * LW),
      .DEPTH (THREAD_COUNT)
   ) u_lmq_ltab (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_wa),
      .wr_data (l_wd),
      .rd_en   (l_re),
      .rd_addr (l_ra),
      .rd_data (l_rd)
   );

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      q_in        = q_ff;
      t_in        = t_ff;
      clr_in      = clr_ff;
      a_addr_in   = a_addr_ff;
      a_nxt_in    = a_nxt_ff;
      a_val_in    = a_val_ff;
      b_en_in     = b_en_ff;
      b_addr_in   = b_addr_ff;
      b_nxt_in    = b_nxt_ff;
      b_val_in    = b_val_ff;
      f_addr_in   = f_addr_ff;
      f_val_in    = f_val_ff;
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      popped_in   = popped_ff;
      empty_in    = empty_ff;
      q_we        = 1'b0;
      q_wa        = q_ff;
      q_wd        = {NONE, NONE};
      q_re        = 1'b0;
      q_ra        = queue_id;
      l_we        = 1'b0;
      l_wa        = f_addr_ff;
      l_wd        = f_val_ff;
      l_re        = 1'b0;
      l_ra        = thread_id;
      done        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep both tables to none, one entry a cycle
            q_we = 1'b1;
            q_wa = clr_ff;
            l_we = (clr_ff != NONE);
            l_wa = clr_ff[TW-1:0];
            l_wd = {NONE, NONE};
            if (clr_ff == NONE) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in = op;
               q_in  = queue_id;
               t_in  = thread_id;
               if (op == OP_NOP) begin
                  popped_in = '0;
                  empty_in  = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  q_re     = 1'b1;
                  l_re     = (op == OP_REM);
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            popped_in = '0;
            empty_in  = 1'b0;
            fwd_in    = 1'b0;
            case (op_ff)
               OP_ENQ: begin
                  q_we      = 1'b1;
                  q_wd      = {is_thread(q_tail) ? q_head : t_ext, t_ext};
                  a_addr_in = q_tail[TW-1:0];
                  a_nxt_in  = 1'b1;
                  a_val_in  = t_ext;
                  b_en_in   = 1'b0;
                  f_addr_in = t_ff;
                  f_val_in  = {NONE, q_tail};
                  if (is_thread(q_tail)) begin
                     l_re     = 1'b1;
                     l_ra     = q_tail[TW-1:0];
                     state_in = ST_RMW_A;
                  end else begin
                     state_in = ST_FINAL;
                  end
               end
               OP_DEQ: begin
                  if (!is_thread(q_head)) begin
                     empty_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     popped_in = q_head[TW-1:0];
                     l_re      = 1'b1;
                     l_ra      = q_head[TW-1:0];
                     f_addr_in = q_head[TW-1:0];
                     f_val_in  = {NONE, NONE};
                     state_in  = ST_HEADLINK;
                  end
               end
               OP_REM: begin
                  q_we      = 1'b1;
                  q_wd      = {(!is_thread(l_prev) && q_head == t_ext) ? l_next : q_head,
                               (!is_thread(l_next) && q_tail == t_ext) ? l_prev : q_tail};
                  a_addr_in = l_prev[TW-1:0];
                  a_nxt_in  = 1'b1;
                  a_val_in  = l_next;
                  b_en_in   = is_thread(l_next);
                  b_addr_in = l_next[TW-1:0];
                  b_nxt_in  = 1'b0;
                  b_val_in  = l_prev;
                  f_addr_in = t_ff;
                  f_val_in  = {NONE, NONE};
                  if (is_thread(l_prev)) begin
                     l_re     = 1'b1;
                     l_ra     = l_prev[TW-1:0];
                     state_in = ST_RMW_A;
                  end else if (is_thread(l_next)) begin
                     l_re     = 1'b1;
                     l_ra     = l_next[TW-1:0];
                     state_in = ST_RMW_B;
                  end else begin
                     state_in = ST_FINAL;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_HEADLINK: begin
            // successor of the popped head becomes the new head
            fwd_in    = 1'b0;
            q_we      = 1'b1;
            q_wd      = {l_next, is_thread(l_next) ? q_tail : NONE};
            b_en_in   = is_thread(l_next);
            b_addr_in = l_next[TW-1:0];
            b_nxt_in  = 1'b0;
            b_val_in  = NONE;
            if (is_thread(l_next)) begin
               l_re     = 1'b1;
               l_ra     = l_next[TW-1:0];
               state_in = ST_RMW_B;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_RMW_A: begin
            l_we = 1'b1;
            l_wa = a_addr_ff;
            l_wd = set_link(l_rd, a_nxt_ff, a_val_ff);
            if (b_en_ff) begin
               // forward when the second patch hits the entry just written
               l_re        = 1'b1;
               l_ra        = b_addr_ff;
               fwd_in      = (b_addr_ff == a_addr_ff);
               fwd_data_in = set_link(l_rd, a_nxt_ff, a_val_ff);
               state_in    = ST_RMW_B;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_RMW_B: begin
            l_we     = 1'b1;
            l_wa     = b_addr_ff;
            l_wd     = set_link(fwd_ff ? fwd_data_ff : l_rd, b_nxt_ff, b_val_ff);
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            l_we     = 1'b1;
            l_wa     = f_addr_ff;
            l_wd     = f_val_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      q_ff        <= q_in;
      t_ff        <= t_in;
      a_addr_ff   <= a_addr_in;
      a_nxt_ff    <= a_nxt_in;
      a_val_ff    <= a_val_in;
      b_en_ff     <= b_en_in;
      b_addr_ff   <= b_addr_in;
      b_nxt_ff    <= b_nxt_in;
      b_val_ff    <= b_val_in;
      f_addr_ff   <= f_addr_in;
      f_val_ff    <= f_val_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      popped_ff   <= popped_in;
      empty_ff    <= empty_in;
   end

   assign ready  = (state_ff == ST_IDLE);
   assign popped = popped_ff;
   assign empty  = empty_ff;

endmodule

### hdl/linked_multi_queue_manager.sv
// Top level: request decode, sequencer and registered result stage.
// A result is registered once its transaction has run through the sequencer states; a request
// that changes nothing skips the table walk, and the longest walks are a dequeue or remove that patches two links.
// One transaction at a time, and a finished one waits while the result register is stalled; the
// single write port of the link table carries one link patch per cycle.
// Reset: synchronous; afterwards a clearing pass sets every head, tail and link to none,
// and no request transaction is taken until it ends.
module linked_multi_queue_manager #(
   parameter int THREAD_COUNT = lmq_pkg::DEF_THREAD_COUNT,
   localparam int TW = $clog2(THREAD_COUNT),
   localparam int LW = $clog2(THREAD_COUNT + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_type,
   input  logic [LW-1:0] req_queue_id,
   input  logic [TW-1:0] req_thread_id,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [TW-1:0] rsp_popped_thread,
   output logic          rsp_queue_was_empty
);

   import lmq_pkg::*;

   localparam logic [LW-1:0] NONE = LW'(THREAD_COUNT);

   logic          queue_ok;
   logic          thread_ok;
   lmq_op_type    req_op;
   logic          seq_ready;
   logic          seq_done;
   logic          slot_free;
   logic [TW-1:0] seq_popped;
   logic          seq_empty;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0] rsp_popped_ff;
   logic          rsp_empty_ff;

   // Range checks: a bad queue, a bad thread or an unused code becomes a no-op
   assign queue_ok  = (req_queue_id <= NONE);
   assign thread_ok = (LW'(req_thread_id) < NONE);

   always_comb begin
      unique case (req_type)
         REQ_ENQUEUE: req_op = (queue_ok && thread_ok) ? OP_ENQ : OP_NOP;
         REQ_DEQUEUE: req_op = queue_ok ? OP_DEQ : OP_NOP;
         REQ_REMOVE:  req_op = (queue_ok && thread_ok) ? OP_REM : OP_NOP;
         default:     req_op = OP_NOP;
      endcase
   end

   // Hold off new transactions while the sequencer is busy or clearing
   assign req_stall = !seq_ready;

   lmq_seq #(
      .THREAD_COUNT (THREAD_COUNT)
   ) u_lmq_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && seq_ready),
      .op        (req_op),
      .queue_id  (req_queue_id),
      .thread_id (req_thread_id),
      .slot_free (slot_free),
      .ready     (seq_ready),
      .done      (seq_done),
      .popped    (seq_popped),
      .empty     (seq_empty)
   );

   // Result register: free when empty or being taken this cycle
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = seq_done || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload only with a new result; hold it while stalled
   always_ff @(posedge clock) begin
      if (seq_done) begin
         rsp_popped_ff <= seq_popped;
         rsp_empty_ff  <= seq_empty;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_popped_thread   = rsp_popped_ff;
   assign rsp_queue_was_empty = rsp_empty_ff;

endmodule

### hdl/lmq_checker.sv
// Port-level checker for the linked multi-queue manager and its bind.
module lmq_checker #(
   parameter int THREAD_COUNT = lmq_pkg::DEF_THREAD_COUNT,
   localparam int TW = $clog2(THREAD_COUNT),
   localparam int LW = $clog2(THREAD_COUNT + 1)
) (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic [1:0]    req_type,
   input logic [LW-1:0] req_queue_id,
   input logic [TW-1:0] req_thread_id,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [TW-1:0] rsp_popped_thread,
   input logic          rsp_queue_was_empty
);

   // no result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one transaction at a time: stall rises right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // an empty report never carries a thread id
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_queue_was_empty) |-> (rsp_popped_thread == '0))
      else $error("empty result with nonzero thread");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_popped_thread)
                                    && $stable(rsp_queue_was_empty)))
      else $error("stalled result changed");

   // stalled request holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_type)
                                    && $stable(req_queue_id) && $stable(req_thread_id)))
      else $error("stalled request changed");

endmodule

bind linked_multi_queue_manager lmq_checker #(
   .THREAD_COUNT (THREAD_COUNT)
) u_lmq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_type            (req_type),
   .req_queue_id        (req_queue_id),
   .req_thread_id       (req_thread_id),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_popped_thread   (rsp_popped_thread),
   .rsp_queue_was_empty (rsp_queue_was_empty)
);
